/* sv/wrsi_pkg.sv */
// ----------------------------------------------------------------------------
// wrsi_pkg
// shared widths, constants, state types and control structs of the wilder
// rsi stream block
// ----------------------------------------------------------------------------
package wrsi_pkg;

  localparam int PRICE_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PERIOD_BITS = 10;
  localparam int AVG_BITS    = PRICE_BITS + FRAC_BITS + PERIOD_BITS;
  localparam int WORD_BITS   = 64;
  localparam int CNT_BITS    = $clog2(WORD_BITS);
  // 100 fits in seven bits
  localparam int SCALE_BITS  = 7;
  localparam int RSI_BITS    = SCALE_BITS + FRAC_BITS;
  localparam int NUM_BITS    = AVG_BITS + SCALE_BITS;
  localparam int QCNT_BITS   = $clog2(RSI_BITS);

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(14);
  localparam logic [RSI_BITS-1:0]    RSI_FULL     = RSI_BITS'(100 << FRAC_BITS);
  localparam logic [RSI_BITS-1:0]    RSI_HALF     = RSI_BITS'(50 << FRAC_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DIV,
    S_POST,
    S_RATIO,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    R_IDLE,
    R_SCALE,
    R_DIV
  } ratio_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
  } lane_ctrl_t;

endpackage

/* sv/wrsi_in_if.sv */
// ----------------------------------------------------------------------------
// wrsi_in_if
// price request channel: valid, ready and one unsigned price
// ----------------------------------------------------------------------------
interface wrsi_in_if;
  logic                            valid;
  logic                            ready;
  logic [wrsi_pkg::PRICE_BITS-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

/* sv/wrsi_out_if.sv */
// ----------------------------------------------------------------------------
// wrsi_out_if
// result request channel: valid, ready, rsi value and warm-up flag
// ----------------------------------------------------------------------------
interface wrsi_out_if;
  logic                          valid;
  logic                          ready;
  logic [wrsi_pkg::RSI_BITS-1:0] rsi;
  logic                          warmed_up;

  modport source (output valid, output rsi, output warmed_up, input ready);
  modport sink   (input valid, input rsi, input warmed_up, output ready);
endinterface

/* sv/wilder_rsi_stream.sv */
// ----------------------------------------------------------------------------
// wilder_rsi_stream
// streaming wilder relative strength index over unsigned price ticks
// ----------------------------------------------------------------------------
// One price request in, one result request out. The first price after reset
// goes from S_PREP straight to S_OUT. Every later price runs through two
// bit-serial lanes (gain and loss), each with one 64-bit shift register:
// lsb-first multiply-accumulate, then msb-first restoring divide by the
// period (by one while still below the period). Once warmed up with a nonzero
// average loss, the ratio unit then forms the 23 quotient bits after a setup
// step. A price is taken only while the block is idle; a finished result
// waits in the output register without holding off the next price. The user
// must write the period register with cfg_we_i only while idle; the block
// itself does not enforce it. Zero acts as one.
// ----------------------------------------------------------------------------
module wilder_rsi_stream (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  wrsi_in_if.sink                           in_i,
  wrsi_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [wrsi_pkg::PERIOD_BITS-1:0]  cfg_data_i
);

  wrsi_pkg::state_e                   state_q, state_d;
  logic [wrsi_pkg::CNT_BITS-1:0]      cnt_q, cnt_d;
  logic [wrsi_pkg::PERIOD_BITS-1:0]   period_q;
  logic                               seen_q;
  logic [wrsi_pkg::PRICE_BITS-1:0]    prev_q;
  logic [wrsi_pkg::PERIOD_BITS-1:0]   count_q;
  logic [wrsi_pkg::AVG_BITS-1:0]      gain_avg_q;
  logic [wrsi_pkg::AVG_BITS-1:0]      loss_avg_q;
  logic                               out_valid_q;

  logic [wrsi_pkg::PRICE_BITS-1:0]    price_q;
  logic [wrsi_pkg::PRICE_BITS-1:0]    delta_q;
  logic                               up_q;
  logic                               warm_q;
  logic [wrsi_pkg::RSI_BITS-1:0]      res_rsi_q;
  logic                               res_warm_q;
  logic [wrsi_pkg::RSI_BITS-1:0]      out_rsi_q;
  logic                               out_warm_q;

  logic                               accept;
  logic [wrsi_pkg::PERIOD_BITS-1:0]   period_eff;
  logic [wrsi_pkg::PERIOD_BITS:0]     count_nx;
  logic                               below;
  logic                               above;
  logic [wrsi_pkg::PERIOD_BITS-1:0]   mult;
  logic [wrsi_pkg::PERIOD_BITS-1:0]   divisor;
  logic [wrsi_pkg::PERIOD_BITS-1:0]   count_sat;
  logic                               price_up;
  logic [wrsi_pkg::PRICE_BITS-1:0]    delta;
  logic                               move_on;
  logic                               gain_bit;
  logic                               loss_bit;
  wrsi_pkg::lane_ctrl_t               lane_ctrl;
  logic [wrsi_pkg::AVG_BITS-1:0]      gain_new;
  logic [wrsi_pkg::AVG_BITS-1:0]      loss_new;
  logic                               ratio_start;
  logic                               ratio_done;
  logic [wrsi_pkg::RSI_BITS-1:0]      ratio_rsi;
  logic                               out_load;

  assign in_i.ready = (state_q == wrsi_pkg::S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // period and warm-up bookkeeping
  always_comb begin
    period_eff = (period_q == '0) ? wrsi_pkg::PERIOD_BITS'(1) : period_q;
    count_nx   = {1'b0, count_q} + 1'b1;
    below      = (count_nx < {1'b0, period_eff});
    above      = (count_nx > {1'b0, period_eff});
    mult       = above ? (period_eff - 1'b1) : wrsi_pkg::PERIOD_BITS'(1);
    divisor    = below ? wrsi_pkg::PERIOD_BITS'(1) : period_eff;
    count_sat  = above ? period_eff : count_nx[wrsi_pkg::PERIOD_BITS-1:0];
    price_up   = (price_q > prev_q);
    delta      = price_up ? (price_q - prev_q) : (prev_q - price_q);
  end

  // move enters the lanes at bit FRAC_BITS
  always_comb begin
    move_on  = (state_q == wrsi_pkg::S_MUL)
            && (cnt_q >= wrsi_pkg::CNT_BITS'(wrsi_pkg::FRAC_BITS));
    gain_bit = move_on && up_q && delta_q[0];
    loss_bit = move_on && !up_q && delta_q[0];
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lane_ctrl   = '0;
    ratio_start = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      wrsi_pkg::S_IDLE: begin
        if (accept) begin
          state_d = wrsi_pkg::S_PREP;
        end
      end
      wrsi_pkg::S_PREP: begin
        if (!seen_q) begin
          state_d = wrsi_pkg::S_OUT;
        end else begin
          lane_ctrl.load = 1'b1;
          cnt_d          = '0;
          state_d        = wrsi_pkg::S_MUL;
        end
      end
      wrsi_pkg::S_MUL: begin
        lane_ctrl.mul = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (&cnt_q) begin
          state_d = wrsi_pkg::S_DIV;
        end
      end
      wrsi_pkg::S_DIV: begin
        lane_ctrl.div = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (&cnt_q) begin
          state_d = wrsi_pkg::S_POST;
        end
      end
      wrsi_pkg::S_POST: begin
        if (warm_q && (loss_new != '0)) begin
          ratio_start = 1'b1;
          state_d     = wrsi_pkg::S_RATIO;
        end else begin
          state_d = wrsi_pkg::S_OUT;
        end
      end
      wrsi_pkg::S_RATIO: begin
        if (ratio_done) begin
          state_d = wrsi_pkg::S_OUT;
        end
      end
      wrsi_pkg::S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = wrsi_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wrsi_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wrsi_pkg::S_IDLE;
      cnt_q       <= '0;
      period_q    <= wrsi_pkg::PERIOD_RESET;
      seen_q      <= 1'b0;
      prev_q      <= '0;
      count_q     <= '0;
      gain_avg_q  <= '0;
      loss_avg_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        period_q <= cfg_data_i;
      end
      if (state_q == wrsi_pkg::S_PREP) begin
        seen_q <= 1'b1;
        prev_q <= price_q;
        if (seen_q) begin
          count_q <= count_sat;
        end
      end
      if (state_q == wrsi_pkg::S_POST) begin
        gain_avg_q <= gain_new;
        loss_avg_q <= loss_new;
      end
      out_valid_q <= out_load || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      price_q <= in_i.price;
    end
    if (state_q == wrsi_pkg::S_PREP) begin
      up_q    <= price_up;
      delta_q <= delta;
      warm_q  <= !below;
      if (!seen_q) begin
        res_rsi_q  <= wrsi_pkg::RSI_HALF;
        res_warm_q <= 1'b0;
      end
    end
    if (move_on) begin
      delta_q <= delta_q >> 1;
    end
    if (state_q == wrsi_pkg::S_POST) begin
      if (!warm_q) begin
        res_rsi_q  <= wrsi_pkg::RSI_HALF;
        res_warm_q <= 1'b0;
      end else if (loss_new == '0) begin
        res_rsi_q  <= wrsi_pkg::RSI_FULL;
        res_warm_q <= 1'b1;
      end
    end
    if ((state_q == wrsi_pkg::S_RATIO) && ratio_done) begin
      res_rsi_q  <= ratio_rsi;
      res_warm_q <= 1'b1;
    end
    if (out_load) begin
      out_rsi_q  <= res_rsi_q;
      out_warm_q <= res_warm_q;
    end
  end

  wrsi_lane u_gain_lane (
    .clk_i      (clk_i),
    .ctrl_i     (lane_ctrl),
    .mult_i     (mult),
    .div_i      (divisor),
    .avg_i      (gain_avg_q),
    .move_bit_i (gain_bit),
    .avg_o      (gain_new)
  );

  wrsi_lane u_loss_lane (
    .clk_i      (clk_i),
    .ctrl_i     (lane_ctrl),
    .mult_i     (mult),
    .div_i      (divisor),
    .avg_i      (loss_avg_q),
    .move_bit_i (loss_bit),
    .avg_o      (loss_new)
  );

  wrsi_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ratio_start),
    .gain_i  (gain_new),
    .loss_i  (loss_new),
    .done_o  (ratio_done),
    .rsi_o   (ratio_rsi)
  );

  assign out_o.valid     = out_valid_q;
  assign out_o.rsi       = out_rsi_q;
  assign out_o.warmed_up = out_warm_q;

endmodule

/* sv/wrsi_lane.sv */
// ----------------------------------------------------------------------------
// wrsi_lane
// one average lane: bit-serial multiply-accumulate (lsb first) followed by a
// bit-serial restoring divide by the period (msb first) in one shift register
// ----------------------------------------------------------------------------
module wrsi_lane (
  input  logic                                clk_i,
  input  wrsi_pkg::lane_ctrl_t                ctrl_i,
  input  logic [wrsi_pkg::PERIOD_BITS-1:0]    mult_i,
  input  logic [wrsi_pkg::PERIOD_BITS-1:0]    div_i,
  input  logic [wrsi_pkg::AVG_BITS-1:0]       avg_i,
  input  logic                                move_bit_i,
  output logic [wrsi_pkg::AVG_BITS-1:0]       avg_o
);

  logic [wrsi_pkg::WORD_BITS-1:0]   sr_q;
  logic [wrsi_pkg::PERIOD_BITS-1:0] mult_q;
  logic [wrsi_pkg::PERIOD_BITS-1:0] div_q;
  logic [wrsi_pkg::PERIOD_BITS-1:0] acc_q;
  logic [wrsi_pkg::PERIOD_BITS-1:0] rem_q;
  logic [wrsi_pkg::PERIOD_BITS:0]   sum;
  logic [wrsi_pkg::PERIOD_BITS:0]   trial;
  logic [wrsi_pkg::PERIOD_BITS:0]   diff;
  logic                             ge;

  always_comb begin
    sum   = {1'b0, acc_q}
          + (sr_q[0] ? {1'b0, mult_q} : '0)
          + {{wrsi_pkg::PERIOD_BITS{1'b0}}, move_bit_i};
    trial = {rem_q, sr_q[wrsi_pkg::WORD_BITS-1]};
    ge    = (trial >= {1'b0, div_q});
    diff  = trial - {1'b0, div_q};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sr_q   <= {{(wrsi_pkg::WORD_BITS - wrsi_pkg::AVG_BITS){1'b0}}, avg_i};
      mult_q <= mult_i;
      div_q  <= div_i;
      acc_q  <= '0;
      rem_q  <= '0;
    end else if (ctrl_i.mul) begin
      // product bit leaves the running sum, enters at the top
      sr_q  <= {sum[0], sr_q[wrsi_pkg::WORD_BITS-1:1]};
      acc_q <= sum[wrsi_pkg::PERIOD_BITS:1];
    end else if (ctrl_i.div) begin
      sr_q  <= {sr_q[wrsi_pkg::WORD_BITS-2:0], ge};
      rem_q <= ge ? diff[wrsi_pkg::PERIOD_BITS-1:0] : trial[wrsi_pkg::PERIOD_BITS-1:0];
    end
  end

  assign avg_o = sr_q[wrsi_pkg::AVG_BITS-1:0];

endmodule

/* sv/wrsi_ratio.sv */
// ----------------------------------------------------------------------------
// wrsi_ratio
// scaled ratio 100 * 2^16 * gain / (gain + loss), one quotient bit per cycle
// ----------------------------------------------------------------------------
module wrsi_ratio (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [wrsi_pkg::AVG_BITS-1:0]    gain_i,
  input  logic [wrsi_pkg::AVG_BITS-1:0]    loss_i,
  output logic                             done_o,
  output logic [wrsi_pkg::RSI_BITS-1:0]    rsi_o
);

  wrsi_pkg::ratio_e                  state_q, state_d;
  logic [wrsi_pkg::QCNT_BITS-1:0]    cnt_q, cnt_d;
  logic                              done_q, done_d;
  logic [wrsi_pkg::AVG_BITS-1:0]     gain_q;
  logic [wrsi_pkg::AVG_BITS:0]       den_q;
  logic [wrsi_pkg::NUM_BITS-1:0]     part_q;
  logic [wrsi_pkg::AVG_BITS:0]       rem_q;
  logic [wrsi_pkg::RSI_BITS-1:0]     num_q;
  logic [wrsi_pkg::RSI_BITS-1:0]     quo_q;
  logic [wrsi_pkg::NUM_BITS-1:0]     gain_ext;
  logic [wrsi_pkg::NUM_BITS-1:0]     scaled;
  logic [wrsi_pkg::AVG_BITS+1:0]     trial;
  logic [wrsi_pkg::AVG_BITS+1:0]     diff;
  logic                              ge;

  always_comb begin
    gain_ext = {{(wrsi_pkg::NUM_BITS - wrsi_pkg::AVG_BITS){1'b0}}, gain_i};
    // 100 = 64 + 32 + 4
    scaled   = part_q + {{(wrsi_pkg::NUM_BITS - wrsi_pkg::AVG_BITS - 2){1'b0}}, gain_q, 2'b00};
    trial    = {rem_q, num_q[wrsi_pkg::RSI_BITS-1]};
    ge       = (trial >= {1'b0, den_q});
    diff     = trial - {1'b0, den_q};
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      wrsi_pkg::R_IDLE: begin
        if (start_i) begin
          state_d = wrsi_pkg::R_SCALE;
        end
      end
      wrsi_pkg::R_SCALE: begin
        cnt_d   = '0;
        state_d = wrsi_pkg::R_DIV;
      end
      wrsi_pkg::R_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == wrsi_pkg::QCNT_BITS'(wrsi_pkg::RSI_BITS - 1)) begin
          done_d  = 1'b1;
          state_d = wrsi_pkg::R_IDLE;
        end
      end
      default: begin
        state_d = wrsi_pkg::R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrsi_pkg::R_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      wrsi_pkg::R_IDLE: begin
        if (start_i) begin
          gain_q <= gain_i;
          den_q  <= {1'b0, gain_i} + {1'b0, loss_i};
          part_q <= (gain_ext << 6) + (gain_ext << 5);
        end
      end
      wrsi_pkg::R_SCALE: begin
        // top bits of the numerator stay below the divisor
        rem_q <= {1'b0, scaled[wrsi_pkg::NUM_BITS-1:wrsi_pkg::SCALE_BITS]};
        num_q <= {scaled[wrsi_pkg::SCALE_BITS-1:0], {wrsi_pkg::FRAC_BITS{1'b0}}};
        quo_q <= '0;
      end
      wrsi_pkg::R_DIV: begin
        rem_q <= ge ? diff[wrsi_pkg::AVG_BITS:0] : trial[wrsi_pkg::AVG_BITS:0];
        num_q <= {num_q[wrsi_pkg::RSI_BITS-2:0], 1'b0};
        quo_q <= {quo_q[wrsi_pkg::RSI_BITS-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  assign done_o = done_q;
  assign rsi_o  = quo_q;

endmodule

/* sv/wrsi_checker.sv */
// ----------------------------------------------------------------------------
// wrsi_checker
// port-level checks of the wilder rsi stream, bound to the top level
// ----------------------------------------------------------------------------
module wrsi_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [wrsi_pkg::RSI_BITS-1:0] out_rsi_i,
  input logic                          out_warm_i
);

  // pending result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_rsi_i) && $stable(out_warm_i))
    else $error("stalled result changed");

  // one price at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("price taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_rsi_i <= wrsi_pkg::RSI_FULL)
    else $error("rsi above full scale");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_warm_i |-> out_rsi_i == wrsi_pkg::RSI_HALF)
    else $error("warm-up result not neutral");

endmodule

bind wilder_rsi_stream wrsi_checker u_wrsi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_rsi_i   (out_o.rsi),
  .out_warm_i  (out_o.warmed_up)
);

/* tb/wilder_rsi_stream_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wilder_rsi_stream_test
// self-checking bench for the streaming wilder rsi block: a short table of
// price requests with hand-read results at reset, the extremes and the
// zero-loss cases, then phases of random price walks and noise under changing
// periods, each result checked against a local fixed-point predictor
// ----------------------------------------------------------------------------
module wilder_rsi_stream_test;

  typedef struct packed {
    logic [wrsi_pkg::RSI_BITS-1:0] rsi;
    logic                          warm;
  } rsi_res_t;

  typedef struct packed {
    logic                            is_cfg;
    logic [wrsi_pkg::PRICE_BITS-1:0] value;
    logic                            typed;
    logic [wrsi_pkg::RSI_BITS-1:0]   rsi;
    logic                            warm;
  } dir_row_t;

  typedef enum logic [2:0] {
    WALK_FINE,
    WALK_COARSE,
    TREND_UP,
    TREND_DOWN,
    NOISE
  } px_mode_e;

  localparam logic PX    = 1'b0;
  localparam logic CFG   = 1'b1;
  localparam logic PRED  = 1'b0;
  localparam logic TYPED = 1'b1;
  localparam int   DIR_N = 27;
  localparam int   PRICE_TARGET = 1900;
  localparam int   WANT_DEPTH   = 16;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{PX,  32'd1000,      TYPED, wrsi_pkg::RSI_HALF, 1'b0},
    '{PX,  32'd1001,      TYPED, wrsi_pkg::RSI_HALF, 1'b0},
    '{PX,  32'd1002,      TYPED, wrsi_pkg::RSI_HALF, 1'b0},
    '{PX,  32'd1003,      TYPED, wrsi_pkg::RSI_HALF, 1'b0},
    '{PX,  32'd1004,      TYPED, wrsi_pkg::RSI_HALF, 1'b0},
    '{PX,  32'd1005,      TYPED, wrsi_pkg::RSI_HALF, 1'b0},
    '{PX,  32'd1006,      TYPED, wrsi_pkg::RSI_HALF, 1'b0},
    '{PX,  32'd1007,      TYPED, wrsi_pkg::RSI_HALF, 1'b0},
    '{PX,  32'd1008,      TYPED, wrsi_pkg::RSI_HALF, 1'b0},
    '{PX,  32'd1009,      TYPED, wrsi_pkg::RSI_HALF, 1'b0},
    '{PX,  32'd1010,      TYPED, wrsi_pkg::RSI_HALF, 1'b0},
    '{PX,  32'd1011,      TYPED, wrsi_pkg::RSI_HALF, 1'b0},
    '{PX,  32'd1012,      TYPED, wrsi_pkg::RSI_HALF, 1'b0},
    '{PX,  32'd1013,      TYPED, wrsi_pkg::RSI_HALF, 1'b0},
    '{PX,  32'd1014,      TYPED, wrsi_pkg::RSI_FULL, 1'b1},
    '{CFG, 32'd1,         PRED,  23'd0,              1'b0},
    '{PX,  32'd0,         TYPED, 23'd0,              1'b1},
    '{PX,  32'hFFFF_FFFF, TYPED, wrsi_pkg::RSI_FULL, 1'b1},
    '{PX,  32'd0,         TYPED, 23'd0,              1'b1},
    '{CFG, 32'd0,         PRED,  23'd0,              1'b0},
    '{PX,  32'd0,         TYPED, wrsi_pkg::RSI_FULL, 1'b1},
    '{CFG, 32'd1023,      PRED,  23'd0,              1'b0},
    '{PX,  32'd5,         TYPED, wrsi_pkg::RSI_HALF, 1'b0},
    '{CFG, 32'd2,         PRED,  23'd0,              1'b0},
    '{PX,  32'd7,         PRED,  23'd0,              1'b0},
    '{PX,  32'd3,         PRED,  23'd0,              1'b0},
    '{PX,  32'd2,         PRED,  23'd0,              1'b0}
  };

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we;
  logic [wrsi_pkg::PERIOD_BITS-1:0] cfg_data;

  wrsi_in_if  price_if ();
  wrsi_out_if result_if ();

  wilder_rsi_stream u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (price_if),
    .out_o      (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  // predictor state
  logic [wrsi_pkg::PERIOD_BITS-1:0] cur_period = wrsi_pkg::PERIOD_RESET;
  logic [wrsi_pkg::PRICE_BITS-1:0]  last_px    = '0;
  logic                             px_seen    = 1'b0;
  logic [wrsi_pkg::PERIOD_BITS-1:0] n_changes  = '0;
  logic [wrsi_pkg::AVG_BITS-1:0]    up_avg     = '0;
  logic [wrsi_pkg::AVG_BITS-1:0]    down_avg   = '0;

  // expected results in request order
  rsi_res_t   want_fifo [WANT_DEPTH];
  logic [3:0] want_wr     = '0;
  logic [3:0] want_rd     = '0;
  int         mismatches  = 0;
  int         prices_sent = 0;
  bit         feed_calm   = 1'b0;
  bit         sink_calm   = 1'b0;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic rsi_res_t wilder_predict(logic [wrsi_pkg::PRICE_BITS-1:0] px);
    logic [63:0]  p;
    logic [63:0]  up;
    logic [63:0]  dn;
    logic [63:0]  cnt;
    logic [127:0] wide;
    rsi_res_t     res;
    res.rsi  = wrsi_pkg::RSI_HALF;
    res.warm = 1'b0;
    p = (cur_period == 0) ? 64'd1 : 64'(cur_period);
    if (!px_seen) begin
      px_seen = 1'b1;
      last_px = px;
      return res;
    end
    up = '0;
    dn = '0;
    if (px > last_px) begin
      up = 64'(px - last_px) << wrsi_pkg::FRAC_BITS;
    end else begin
      dn = 64'(last_px - px) << wrsi_pkg::FRAC_BITS;
    end
    cnt = 64'(n_changes) + 64'd1;
    if (cnt < p) begin
      up_avg   = wrsi_pkg::AVG_BITS'(64'(up_avg) + up);
      down_avg = wrsi_pkg::AVG_BITS'(64'(down_avg) + dn);
    end else if (cnt == p) begin
      up_avg   = wrsi_pkg::AVG_BITS'((64'(up_avg) + up) / p);
      down_avg = wrsi_pkg::AVG_BITS'((64'(down_avg) + dn) / p);
    end else begin
      // products wrap at 64 bits like the serial lanes
      up_avg   = wrsi_pkg::AVG_BITS'((64'(up_avg) * (p - 64'd1) + up) / p);
      down_avg = wrsi_pkg::AVG_BITS'((64'(down_avg) * (p - 64'd1) + dn) / p);
    end
    n_changes = (cnt > p) ? wrsi_pkg::PERIOD_BITS'(p) : wrsi_pkg::PERIOD_BITS'(cnt);
    last_px   = px;
    if (cnt >= p) begin
      res.warm = 1'b1;
      if (down_avg == 0) begin
        res.rsi = wrsi_pkg::RSI_FULL;
      end else begin
        wide    = (128'(up_avg) * 128'(wrsi_pkg::RSI_FULL))
                / (128'(up_avg) + 128'(down_avg));
        res.rsi = wide[wrsi_pkg::RSI_BITS-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic [wrsi_pkg::PRICE_BITS-1:0] next_price(
      px_mode_e m, logic [wrsi_pkg::PRICE_BITS-1:0] cur);
    logic [wrsi_pkg::PRICE_BITS:0]   sum;
    logic [wrsi_pkg::PRICE_BITS-1:0] step;
    bit                              rise;
    rise = ($urandom_range(0, 1) != 0);
    step = $urandom_range(0, 40);
    case (m)
      WALK_COARSE: step = $urandom_range(0, 32'h00FF_FFFF);
      TREND_UP:    rise = ($urandom_range(0, 7) != 0);
      TREND_DOWN:  rise = ($urandom_range(0, 7) == 0);
      NOISE: begin
        case ($urandom_range(0, 7))
          0:       return '0;
          1:       return '1;
          default: return $urandom;
        endcase
      end
      default: ;
    endcase
    if (rise) begin
      sum = {1'b0, cur} + step;
      return sum[wrsi_pkg::PRICE_BITS] ? '1 : sum[wrsi_pkg::PRICE_BITS-1:0];
    end
    return (step > cur) ? '0 : cur - step;
  endfunction

  task automatic send_price(input logic [wrsi_pkg::PRICE_BITS-1:0] px,
                            input logic typed, input rsi_res_t typed_res);
    int       gap;
    rsi_res_t want;
    gap = pick_gap(feed_calm);
    if (gap > 0) begin
      price_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    price_if.valid <= 1'b1;
    price_if.price <= px;
    @(posedge clk_i);
    while (!price_if.ready) @(posedge clk_i);
    want = wilder_predict(px);
    want_fifo[want_wr] = typed ? typed_res : want;
    want_wr = want_wr + 4'd1;
    prices_sent++;
  endtask

  task automatic wait_drained();
    price_if.valid <= 1'b0;
    while (want_wr != want_rd) @(posedge clk_i);
  endtask

  task automatic set_period(input logic [wrsi_pkg::PERIOD_BITS-1:0] value);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    cur_period = value;
  endtask

  // result side: random back-pressure and checking
  initial begin
    int       stall;
    rsi_res_t want;
    stall = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_if.valid && result_if.ready) begin
        if (want_wr == want_rd) begin
          $error("unexpected result request: rsi %0d warmed_up %0b",
                 result_if.rsi, result_if.warmed_up);
          mismatches++;
        end else begin
          want    = want_fifo[want_rd];
          want_rd = want_rd + 4'd1;
          if (result_if.rsi !== want.rsi) begin
            $error("rsi: expected %0d, got %0d", want.rsi, result_if.rsi);
            mismatches++;
          end
          if (result_if.warmed_up !== want.warm) begin
            $error("warmed_up: expected %0b, got %0b", want.warm, result_if.warmed_up);
            mismatches++;
          end
        end
      end
      if (stall == 0 && $urandom_range(0, 3) == 0) stall = pick_gap(sink_calm);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        stall--;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    rsi_res_t                         typed_res;
    logic [wrsi_pkg::PRICE_BITS-1:0]  px;
    logic [wrsi_pkg::PERIOD_BITS-1:0] per;
    px_mode_e                         mode;
    int                               phase_no;
    int                               phase_len;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    price_if.valid = 1'b0;
    price_if.price = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].is_cfg) begin
        set_period(DIR_ROWS[i].value[wrsi_pkg::PERIOD_BITS-1:0]);
      end else begin
        typed_res.rsi  = DIR_ROWS[i].rsi;
        typed_res.warm = DIR_ROWS[i].warm;
        send_price(DIR_ROWS[i].value, DIR_ROWS[i].typed, typed_res);
      end
    end

    px       = DIR_ROWS[DIR_N-1].value;
    phase_no = 0;
    while (prices_sent < PRICE_TARGET) begin
      case ($urandom_range(0, 15))
        0:       per = '0;
        1:       per = wrsi_pkg::PERIOD_BITS'(1);
        2:       per = '1;
        3:       per = wrsi_pkg::PERIOD_BITS'(2);
        default: per = wrsi_pkg::PERIOD_BITS'($urandom_range(3, 30));
      endcase
      if (phase_no == 3) per = '1;
      // now and then keep the period and only let the block drain
      if (phase_no != 3 && $urandom_range(0, 5) == 0) begin
        wait_drained();
      end else begin
        set_period(per);
      end
      feed_calm = ($urandom_range(0, 4) == 0);
      sink_calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mode = WALK_FINE;
        4, 5:       mode = WALK_COARSE;
        6:          mode = TREND_UP;
        7:          mode = TREND_DOWN;
        default:    mode = NOISE;
      endcase
      if ($urandom_range(0, 1) == 0) px = $urandom;
      // one full warm-up at the longest period
      phase_len = (phase_no == 3) ? 1030 : $urandom_range(10, 80);
      repeat (phase_len) begin
        px = next_price(mode, px);
        send_price(px, PRED, '0);
      end
      phase_no++;
    end

    feed_calm = 1'b0;
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** wilder_rsi_stream: PASSED **");
    end else begin
      $display("** wilder_rsi_stream: FAILED **");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("** wilder_rsi_stream: FAILED **");
    $finish;
  end

endmodule

/* files.f */
sv/wrsi_pkg.sv
sv/wrsi_in_if.sv
sv/wrsi_out_if.sv
sv/wrsi_lane.sv
sv/wrsi_ratio.sv
sv/wilder_rsi_stream.sv
sv/wrsi_checker.sv
tb/wilder_rsi_stream_test.sv
